[sv/hbb_pkg.sv]
package hbb_pkg;

  // Default width of a temperature sample.
  localparam int TEMP_WIDTH_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // Register field widths.
  localparam int SP_W    = 16;
  localparam int LIMIT_W = 15;
  localparam int COUNT_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_SET_POINT        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMPERATURE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_OVERSHOOT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_APPROACH_EPSILON = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_ON_COUNT     = 3'd5;

  // Operation codes carried by an input transaction.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ENABLE  = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;

  // Register reset values.
  localparam logic [SP_W-1:0]    SET_POINT_RST        = 16'sd0;
  localparam logic [SP_W-1:0]    MAX_TEMPERATURE_RST  = 16'h7FFF;
  localparam logic [LIMIT_W-1:0] MAX_OVERSHOOT_RST    = 15'h7FFF;
  localparam logic [LIMIT_W-1:0] APPROACH_EPSILON_RST = 15'd0;
  localparam logic [LIMIT_W-1:0] HYSTERESIS_RST       = 15'd16;
  localparam logic [COUNT_W-1:0] MIN_ON_COUNT_RST     = 16'd1;

  typedef enum logic [1:0] {
    MODE_COOLING     = 2'd0,
    MODE_MAINTAINING = 2'd1,
    MODE_APPROACHING = 2'd2
  } mode_t;

  // Register bank contents, as seen by the regulator.
  typedef struct packed {
    logic [SP_W-1:0]    set_point;
    logic [SP_W-1:0]    max_temperature;
    logic [LIMIT_W-1:0] max_overshoot;
    logic [LIMIT_W-1:0] approach_epsilon;
    logic [LIMIT_W-1:0] hysteresis;
    logic [COUNT_W-1:0] min_on_count;
  } cfg_t;

endpackage

[sv/hbb_in_if.sv]
interface hbb_in_if #(
  parameter int TEMP_WIDTH = hbb_pkg::TEMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic signed [TEMP_WIDTH-1:0] temperature;

  modport source (output valid, output op, output temperature, input ready);
  modport sink   (input valid, input op, input temperature, output ready);
endinterface

[sv/hbb_out_if.sv]
interface hbb_out_if;
  logic       valid;
  logic       ready;
  logic       heater_on;
  logic       is_enabled;
  logic [1:0] mode;
  logic       overshoot_fault;

  modport source (output valid, output heater_on, output is_enabled, output mode,
                  output overshoot_fault, input ready);
  modport sink   (input valid, input heater_on, input is_enabled, input mode,
                  input overshoot_fault, output ready);
endinterface

[sv/hbb_cfg.sv]
module hbb_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hbb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hbb_pkg::cfg_t                      cfg
);
  import hbb_pkg::*;

  // Register bank: each write keeps the low bits that the register holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_point        <= SET_POINT_RST;
      cfg.max_temperature  <= MAX_TEMPERATURE_RST;
      cfg.max_overshoot    <= MAX_OVERSHOOT_RST;
      cfg.approach_epsilon <= APPROACH_EPSILON_RST;
      cfg.hysteresis       <= HYSTERESIS_RST;
      cfg.min_on_count     <= MIN_ON_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_POINT:        cfg.set_point        <= cfg_data[SP_W-1:0];
        REG_MAX_TEMPERATURE:  cfg.max_temperature  <= cfg_data[SP_W-1:0];
        REG_MAX_OVERSHOOT:    cfg.max_overshoot    <= cfg_data[LIMIT_W-1:0];
        REG_APPROACH_EPSILON: cfg.approach_epsilon <= cfg_data[LIMIT_W-1:0];
        REG_HYSTERESIS:       cfg.hysteresis       <= cfg_data[LIMIT_W-1:0];
        REG_MIN_ON_COUNT:     cfg.min_on_count     <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/heater_bang_bang_controller.sv]
// Channel   Direction  Payload                                       Accepted when
// req       in         op, temperature                               req.valid && req.ready
// rsp       out        heater_on, is_enabled, mode, overshoot_fault  rsp.valid && rsp.ready
// cfg_*     in         cfg_index, cfg_data                           cfg_we high at the edge
//
// One transaction per cycle while rsp does not stall: every item is worked out in the cycle
// it is accepted, and its result is captured in the output register on acceptance.
// The rate is set by a single pass of comparators and the on-count incrementer.
// Synchronous reset clears the controller state and the output valid; registers take
// their default values. No clearing pass is needed.
// req.ready is high whenever the output register is empty or being read in the same
// cycle, so a stall on rsp holds back at most one result.
module heater_bang_bang_controller #(
  parameter int TEMP_WIDTH = hbb_pkg::TEMP_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  hbb_in_if.sink                          req,
  hbb_out_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [hbb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hbb_pkg::*;

  // Error width: wide enough for set point minus sample and for the 15-bit limits.
  localparam int EW = ((TEMP_WIDTH + 1 > LIMIT_W + 1) ? TEMP_WIDTH + 1 : LIMIT_W + 1) + 1;

  cfg_t cfg;

  hbb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Controller state.
  logic               enabled;
  logic               enabled_next;
  mode_t              mode;
  mode_t              mode_next;
  logic [COUNT_W-1:0] on_count;
  logic [COUNT_W-1:0] on_count_next;
  logic               relay;
  logic               relay_next;
  logic               fault_next;

  // Output register.
  logic       out_valid;
  logic       out_heater_on;
  logic       out_is_enabled;
  logic [1:0] out_mode;
  logic       out_fault;

  logic accept;

  // Signed views of the sample and the limits.
  logic signed [TEMP_WIDTH-1:0] temp_s;
  logic signed [TEMP_WIDTH-1:0] sp_s;
  logic signed [TEMP_WIDTH-1:0] tmax_s;
  logic signed [EW-1:0]         err;
  logic signed [EW-1:0]         hy_pos;
  logic signed [EW-1:0]         hy_neg;
  logic signed [EW-1:0]         eps_pos;
  logic signed [EW-1:0]         ovs_neg;
  logic                         watchdog_trip;

  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;

  // Registers are 16 bits wide; they are taken at the sample width, as for a sample.
  assign temp_s  = req.temperature;
  assign sp_s    = signed'(TEMP_WIDTH'(cfg.set_point));
  assign tmax_s  = signed'(TEMP_WIDTH'(cfg.max_temperature));
  assign err     = EW'(sp_s) - EW'(temp_s);
  assign hy_pos  = signed'(EW'(cfg.hysteresis));
  assign hy_neg  = -hy_pos;
  assign eps_pos = signed'(EW'(cfg.approach_epsilon));
  assign ovs_neg = -signed'(EW'(cfg.max_overshoot));

  assign watchdog_trip = (temp_s >= tmax_s) || (err <= ovs_neg);

  // Next state for one input transaction.
  always_comb begin
    enabled_next  = enabled;
    mode_next     = mode;
    on_count_next = on_count;
    relay_next    = relay;
    fault_next    = 1'b0;
    case (req.op)
      OP_ENABLE: begin
        enabled_next  = 1'b1;
        mode_next     = MODE_MAINTAINING;
        on_count_next = '0;
      end
      OP_DISABLE: begin
        enabled_next  = 1'b0;
        mode_next     = MODE_COOLING;
        on_count_next = '0;
        relay_next    = 1'b0;
      end
      OP_TICK: begin
        if (enabled) begin
          if (on_count >= cfg.min_on_count) begin
            // Enough heating cycles seen: run on the plain epsilon threshold.
            mode_next = MODE_APPROACHING;
            if (err > eps_pos) begin
              relay_next    = 1'b1;
              on_count_next = (on_count == '1) ? on_count : on_count + 1'b1;
            end else begin
              relay_next = 1'b0;
            end
          end else begin
            // Hysteresis band; the count restarts at one when the heater turns on and clears otherwise.
            mode_next = MODE_MAINTAINING;
            if (err >= hy_pos) begin
              relay_next    = 1'b1;
              on_count_next = COUNT_W'(1);
            end else if (err <= hy_neg) begin
              relay_next    = 1'b0;
              on_count_next = '0;
            end else begin
              on_count_next = '0;
            end
          end
        end else begin
          mode_next = MODE_COOLING;
        end
        // The watchdog acts on every tick and overrides the regulator.
        if (watchdog_trip) begin
          enabled_next  = 1'b0;
          mode_next     = MODE_COOLING;
          on_count_next = '0;
          relay_next    = 1'b0;
          fault_next    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State update on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled  <= 1'b0;
      mode     <= MODE_COOLING;
      on_count <= '0;
      relay    <= 1'b0;
    end else if (accept) begin
      enabled  <= enabled_next;
      mode     <= mode_next;
      on_count <= on_count_next;
      relay    <= relay_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_heater_on  <= relay_next;
      out_is_enabled <= enabled_next;
      out_mode       <= mode_next;
      out_fault      <= fault_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.heater_on       = out_heater_on;
  assign rsp.is_enabled      = out_is_enabled;
  assign rsp.mode            = out_mode;
  assign rsp.overshoot_fault = out_fault;

  // A tripped watchdog always leaves the block disabled with the heater off.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.overshoot_fault |-> !rsp.is_enabled && !rsp.heater_on
  ) else $error("fault reported with the controller still active");

  // While disabled the controller is idle: cooling, relay off, count clear.
  assert property (@(posedge clk) disable iff (rst)
    !enabled |-> (mode == MODE_COOLING) && !relay && (on_count == '0)
  ) else $error("disabled controller holds active state");

  // State moves only on an accepted transaction.
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(enabled) && $stable(mode) && $stable(on_count) && $stable(relay)
  ) else $error("controller state changed without a transaction");

  // A new result lands whenever one is accepted, so no result is dropped or stalled out.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid
  ) else $error("accepted transaction produced no result");

endmodule
